[rtl/core/ifs_pkg.sv]
package ifs_pkg;

  // width of the reported value field, and the default accumulator width
  localparam int unsigned FieldValueW = 64;
  localparam int unsigned ValueBitsDefault = 64;
  localparam int unsigned CountW = 7;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 7;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgConvMode = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxWidth = 1'b1;

  // conversion modes
  localparam logic [2:0] ModeSdec = 3'd0;
  localparam logic [2:0] ModeUdec = 3'd1;
  localparam logic [2:0] ModeOct  = 3'd2;
  localparam logic [2:0] ModeHex  = 3'd3;
  localparam logic [2:0] ModeAuto = 3'd4;

  // scan phases
  localparam logic [2:0] PhStart    = 3'd0;
  localparam logic [2:0] PhSigned   = 3'd1;
  localparam logic [2:0] PhLeadZero = 3'd2;
  localparam logic [2:0] PhPrefix   = 3'd3;
  localparam logic [2:0] PhDigits   = 3'd4;
  localparam logic [2:0] PhDone     = 3'd5;

  // chosen base
  localparam logic [1:0] BaseDec = 2'd0;
  localparam logic [1:0] BaseOct = 2'd1;
  localparam logic [1:0] BaseHex = 2'd2;

  // characters
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharLowX  = 8'h78;
  localparam logic [7:0] CharUpX   = 8'h58;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef struct packed {
    logic       start_field;
    logic [7:0] char_code;
  } in_word_t;

  typedef struct packed {
    logic                   consumed;
    logic                   field_done;
    logic                   field_error;
    logic [FieldValueW-1:0] field_value;
    logic [CountW-1:0]      chars_taken;
  } out_word_t;

  // per-field scan state, apart from the value accumulators
  typedef struct packed {
    logic [2:0]        phase;
    logic              minus_seen;
    logic              digit_seen;
    logic [1:0]        base;
    logic [CountW-1:0] taken;
  } scan_ctl_t;

  function automatic logic is_num(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic is_hex_alpha(input logic [7:0] c);
    return ((c >= CharLowA) && (c <= CharLowF)) || ((c >= CharUpA) && (c <= CharUpF));
  endfunction

  // digit value, base independent (letters a-f map to 10-15)
  function automatic logic [3:0] digit_val(input logic [7:0] c);
    logic [3:0] v;
    if (is_num(c)) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic logic digit_ok(input logic [7:0] c, input logic [1:0] base);
    logic ok;
    case (base)
      BaseOct: ok = is_num(c) && (c[3:0] < 4'd8);
      BaseHex: ok = is_num(c) || is_hex_alpha(c);
      default: ok = is_num(c);
    endcase
    return ok;
  endfunction

endpackage

[rtl/core/ifs_in_stage.sv]
module ifs_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ifs_pkg::in_word_t in_word_i,
  input  logic             advance_i,
  output logic             valid_o,
  output ifs_pkg::in_word_t word_o
);
  import ifs_pkg::*;

  logic     valid_q;
  in_word_t word_q;
  logic     load;

  // holding register frees up in the same cycle it is drained
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= in_word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

[rtl/core/ifs_step.sv]
module ifs_step #(
  parameter int unsigned VALUE_BITS = ifs_pkg::ValueBitsDefault
) (
  input  ifs_pkg::in_word_t  word_i,
  input  logic [2:0]         conv_mode_i,
  input  logic [ifs_pkg::CountW-1:0] max_width_i,
  input  ifs_pkg::scan_ctl_t ctl_i,
  input  logic [VALUE_BITS-1:0] acc_i,
  input  logic [VALUE_BITS-1:0] nacc_i,
  output ifs_pkg::scan_ctl_t ctl_o,
  output logic [VALUE_BITS-1:0] acc_o,
  output logic [VALUE_BITS-1:0] nacc_o,
  output ifs_pkg::out_word_t result_o
);
  import ifs_pkg::*;

  scan_ctl_t             cur;
  scan_ctl_t             nxt;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] nacc;
  logic [VALUE_BITS-1:0] acc_scaled;
  logic [VALUE_BITS-1:0] nacc_scaled;
  logic [VALUE_BITS-1:0] dig_ext;
  logic [7:0]            c;
  logic [2:0]            mode_eff;
  logic [1:0]            start_base;
  logic                  take;
  logic                  do_acc;
  logic                  zero_acc;
  logic                  limit_hit;
  logic [CountW-1:0]     taken_inc;

  always_comb begin
    c = word_i.char_code;

    // a new field starts from cleared state
    if (word_i.start_field) begin
      cur.phase      = PhStart;
      cur.minus_seen = 1'b0;
      cur.digit_seen = 1'b0;
      cur.base       = BaseDec;
      cur.taken      = '0;
      acc            = '0;
      nacc           = '0;
    end else begin
      cur  = ctl_i;
      acc  = acc_i;
      nacc = nacc_i;
    end

    mode_eff   = (conv_mode_i > ModeAuto) ? ModeSdec : conv_mode_i;
    start_base = (mode_eff == ModeOct) ? BaseOct :
                 ((mode_eff == ModeHex) ? BaseHex : BaseDec);
    limit_hit  = (max_width_i != '0) && (cur.taken >= max_width_i);
    taken_inc  = (cur.taken == CountMax) ? cur.taken : cur.taken + 1'b1;

    nxt      = cur;
    take     = 1'b0;
    do_acc   = 1'b0;
    zero_acc = 1'b0;

    if ((cur.phase > PhDigits) || limit_hit) begin
      nxt.phase = PhDone;
    end else begin
      if ((cur.phase == PhStart) && ((c == CharPlus) || (c == CharMinus))) begin
        nxt.minus_seen = (c == CharMinus);
        nxt.phase      = PhSigned;
        take           = 1'b1;
      end else if ((cur.phase == PhStart) || (cur.phase == PhSigned)) begin
        nxt.base = start_base;
        if ((c == CharZero) && ((mode_eff == ModeHex) || (mode_eff == ModeAuto))) begin
          nxt.base       = (mode_eff == ModeHex) ? BaseHex : BaseOct;
          zero_acc       = 1'b1;
          nxt.digit_seen = 1'b1;
          nxt.phase      = PhLeadZero;
          take           = 1'b1;
        end else if (digit_ok(c, start_base)) begin
          do_acc    = 1'b1;
          nxt.phase = PhDigits;
          take      = 1'b1;
        end
      end else if ((cur.phase == PhLeadZero) && ((c == CharLowX) || (c == CharUpX))) begin
        nxt.base  = BaseHex;
        nxt.phase = PhPrefix;
        take      = 1'b1;
      end else if (digit_ok(c, cur.base)) begin
        do_acc    = 1'b1;
        nxt.phase = PhDigits;
        take      = 1'b1;
      end

      if (take) begin
        nxt.taken = taken_inc;
        if ((max_width_i != '0) && (taken_inc >= max_width_i)) begin
          nxt.phase = PhDone;
        end
      end else begin
        nxt.phase = PhDone;
      end
    end

    // radix multiply as shifts and adds, tracking the negated value alongside
    case (nxt.base)
      BaseOct: begin
        acc_scaled  = acc << 3;
        nacc_scaled = nacc << 3;
      end
      BaseHex: begin
        acc_scaled  = acc << 4;
        nacc_scaled = nacc << 4;
      end
      default: begin
        acc_scaled  = (acc << 3) + (acc << 1);
        nacc_scaled = (nacc << 3) + (nacc << 1);
      end
    endcase
    dig_ext = VALUE_BITS'(digit_val(c));

    if (zero_acc) begin
      acc_o  = '0;
      nacc_o = '0;
    end else if (do_acc) begin
      acc_o          = acc_scaled + dig_ext;
      nacc_o         = nacc_scaled - dig_ext;
      nxt.digit_seen = 1'b1;
    end else begin
      acc_o  = acc;
      nacc_o = nacc;
    end

    ctl_o = nxt;

    result_o.consumed    = take;
    result_o.field_done  = (nxt.phase == PhDone);
    result_o.field_error = (nxt.phase == PhDone) && !nxt.digit_seen;
    result_o.field_value = FieldValueW'(nxt.minus_seen ? nacc_o : acc_o);
    result_o.chars_taken = nxt.taken;
  end

endmodule

[rtl/core/integer_field_scanner.sv]
// integer_field_scanner: scans one integer text field a character at a time,
// the way scanf integer conversions do (signed or unsigned decimal, octal,
// hex with optional 0x prefix, or auto base). Every accepted word yields one
// result word with consumed, done, error, the value so far (two's complement
// negated when a minus sign was read, wrapping at VALUE_BITS) and the count of
// characters taken. Set start_field on the first character of each field.
// A character enters every clock while the output is not stalled; each one
// passes the input holding register and then the result register. The
// per-character state update (radix shift-add into the accumulator) is
// combinational, which is what allows that rate. Configuration (mode and
// width limit) is written through cfg_we_i/cfg_addr_i/cfg_data_i and must only
// change while no words are in flight.
module integer_field_scanner #(
  parameter int unsigned VALUE_BITS = ifs_pkg::ValueBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [ifs_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [ifs_pkg::CfgDataW-1:0] cfg_data_i,
  // character input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ifs_pkg::in_word_t            in_word_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ifs_pkg::out_word_t           out_word_o
);
  import ifs_pkg::*;

  // configuration registers
  logic [2:0]        conv_mode_q;
  logic [CountW-1:0] max_width_q;

  // holding register between input and step logic
  logic     hold_valid;
  in_word_t hold_word;
  logic     advance;

  // field state
  scan_ctl_t             ctl_q;
  scan_ctl_t             ctl_d;
  logic [VALUE_BITS-1:0] acc_q;
  logic [VALUE_BITS-1:0] acc_d;
  logic [VALUE_BITS-1:0] nacc_q;
  logic [VALUE_BITS-1:0] nacc_d;

  // result register
  logic      out_valid_q;
  out_word_t out_word_q;
  out_word_t out_word_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_mode_q <= ModeSdec;
      max_width_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgConvMode: conv_mode_q <= cfg_data_i[2:0];
        CfgMaxWidth: max_width_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // a held word moves on when the result register is empty or being drained
  assign advance = hold_valid && (!out_valid_q || !out_stall_i);

  ifs_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .advance_i  (advance),
    .valid_o    (hold_valid),
    .word_o     (hold_word)
  );

  ifs_step #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step (
    .word_i      (hold_word),
    .conv_mode_i (conv_mode_q),
    .max_width_i (max_width_q),
    .ctl_i       (ctl_q),
    .acc_i       (acc_q),
    .nacc_i      (nacc_q),
    .ctl_o       (ctl_d),
    .acc_o       (acc_d),
    .nacc_o      (nacc_d),
    .result_o    (out_word_d)
  );

  // field state only moves when a word is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.phase      <= PhStart;
      ctl_q.minus_seen <= 1'b0;
      ctl_q.digit_seen <= 1'b0;
      ctl_q.base       <= BaseDec;
      ctl_q.taken      <= '0;
      acc_q            <= '0;
      nacc_q           <= '0;
    end else if (advance) begin
      ctl_q  <= ctl_d;
      acc_q  <= acc_d;
      nacc_q <= nacc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
